// ===== rtl/lzsswd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor package
// Shared constants, types and handshake structs of the decompressor core.
// ----------------------------------------------------------------------------
package lzsswd_pkg;

    // Token format: window position bits and copy length bits.
    localparam int WINDOW_BITS = 8;
    localparam int LENGTH_BITS = 4;

    localparam int WIN_SIZE   = 1 << WINDOW_BITS;
    localparam int MATCH_BITS = WINDOW_BITS + LENGTH_BITS;
    localparam int BYTE_BITS  = 8;
    localparam int CNT_W      = 32;

    // The accumulator must hold either a literal or a full match field.
    localparam int ACC_W  = (MATCH_BITS > BYTE_BITS) ? MATCH_BITS : BYTE_BITS;
    localparam int HELD_W = $clog2(ACC_W + 1);
    localparam int LEN_W  = LENGTH_BITS + 1;
    localparam int BL_W   = $clog2(BYTE_BITS + 1);

    typedef logic [WINDOW_BITS-1:0] win_addr_t;
    typedef logic [BYTE_BITS-1:0]   byte_t;
    typedef logic [CNT_W-1:0]       count_t;

    // Write pointer start: window size minus (2^LENGTH_BITS + 1), wrapped.
    localparam win_addr_t PTR_START = win_addr_t'(WIN_SIZE - (2 ** LENGTH_BITS) - 1);
    localparam count_t    CNT_MAX   = '1;

    // Decoder to output buffer: one result and the end-of-byte flush request.
    typedef struct packed {
        logic  res_valid;
        byte_t res_data;
        logic  res_finished;
        logic  flush;
    } lzsswd_buf_ctrl_t;

    // Output buffer to decoder.
    typedef struct packed {
        logic res_ready;
        logic flush_done;
    } lzsswd_buf_status_t;

endpackage

// ===== rtl/lzsswd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with enable; read data is registered.
// ----------------------------------------------------------------------------
module lzsswd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Synchronous write and read; a read at the written address returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lzsswd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS output buffer
// Holds one pending result until it is known whether it ends its input byte,
// then moves it into the output register with the proper last_of_run flag.
// ----------------------------------------------------------------------------
module lzsswd_out_buf
    import lzsswd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lzsswd_buf_ctrl_t   buf_ctrl,
    output lzsswd_buf_status_t buf_status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               last_of_run,
    output logic               finished
);

    logic  pend_valid_reg, pend_valid_next;
    byte_t pend_data_reg, pend_data_next;
    logic  pend_fin_reg, pend_fin_next;
    logic  out_valid_reg, out_valid_next;
    byte_t out_data_reg, out_data_next;
    logic  out_last_reg, out_last_next;
    logic  out_fin_reg, out_fin_next;
    logic  out_free;

    // The output register frees up when it is empty or its transaction completes.
    assign out_free              = !out_valid_reg || out_ready;
    assign buf_status.res_ready  = !pend_valid_reg || out_free;
    assign buf_status.flush_done = !pend_valid_reg || out_free;

    // Pending slot and output register movement.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_fin_next   = pend_fin_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_fin_next    = out_fin_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (buf_ctrl.res_valid && buf_status.res_ready)
        begin
            // A newer result exists, so the pending one is not the last.
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pend_data_reg;
                out_fin_next   = pend_fin_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_data_next  = buf_ctrl.res_data;
            pend_fin_next   = buf_ctrl.res_finished;
        end
        else if (buf_ctrl.flush && pend_valid_reg && out_free)
        begin
            // End of the input byte: the pending result closes the run.
            out_valid_next  = 1'b1;
            out_data_next   = pend_data_reg;
            out_fin_next    = pend_fin_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_data_reg <= pend_data_next;
        pend_fin_reg  <= pend_fin_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_fin_reg   <= out_fin_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_data_reg;
    assign last_of_run = out_last_reg;
    assign finished    = out_fin_reg;

endmodule

// ===== rtl/lzsswd_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS token decoder
// Walks each compressed byte one bit per cycle unless stalled, emits literals
// and copies matches through the window RAM, read-modify-write with forwarding.
// ----------------------------------------------------------------------------
module lzsswd_decoder
    import lzsswd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [31:0]        total_length,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    output lzsswd_buf_ctrl_t   buf_ctrl,
    input  lzsswd_buf_status_t buf_status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BITS,
        ST_CP_ISSUE,
        ST_CP_DATA,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_MATCH
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    win_addr_t         clr_idx_reg, clr_idx_next;
    byte_t             byte_reg, byte_next;
    logic [BL_W-1:0]   bits_left_reg, bits_left_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    win_addr_t         wp_reg, wp_next;
    win_addr_t         rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    count_t            count_reg, count_next;
    count_t            total_reg, total_next;
    logic              fwd_reg, fwd_next;
    byte_t             fwd_data_reg, fwd_data_next;

    logic              bit_in;
    logic [ACC_W-1:0]  acc_new;
    logic [HELD_W-1:0] held_new;
    logic              adv;
    logic              go_copy;
    logic              emit;
    byte_t             emit_data;
    count_t            count_inc;
    byte_t             cp_data;
    logic              ram_we;
    win_addr_t         ram_waddr;
    byte_t             ram_wdata;
    logic              ram_re;
    byte_t             ram_rdata;

    // Window storage.
    lzsswd_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (WIN_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Bit shift into the token accumulator and saturating output count.
    assign bit_in    = byte_reg[BYTE_BITS-1];
    assign acc_new   = {acc_reg[ACC_W-2:0], bit_in};
    assign held_new  = held_reg + 1'b1;
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign cp_data   = fwd_reg ? fwd_data_reg : ram_rdata;

    // Window write port: clearing sweep after reset, otherwise every emitted byte.
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : wp_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : emit_data;

    assign in_ready = (state_reg == ST_IDLE);

    assign buf_ctrl.res_valid    = emit;
    assign buf_ctrl.res_data     = emit_data;
    assign buf_ctrl.res_finished = (count_inc >= total_reg);
    assign buf_ctrl.flush        = (state_reg == ST_FLUSH);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        clr_idx_next   = clr_idx_reg;
        byte_next      = byte_reg;
        bits_left_next = bits_left_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        wp_next        = wp_reg;
        rd_ptr_next    = rd_ptr_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        adv            = 1'b0;
        go_copy        = 1'b0;
        emit           = 1'b0;
        emit_data      = cp_data;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (cfg_valid)
        begin
            total_next = total_length;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next      = in_byte;
                    bits_left_next = BL_W'(BYTE_BITS);
                    state_next     = ST_BITS;
                end
            end

            ST_BITS:
            begin
                case (phase_reg)
                    PH_FLAG:
                    begin
                        // Once the stream is done, flag bits are dropped.
                        adv = 1'b1;
                        if (count_reg < total_reg)
                        begin
                            phase_next = bit_in ? PH_LIT : PH_MATCH;
                            acc_next   = '0;
                            held_next  = '0;
                        end
                    end

                    PH_LIT:
                    begin
                        if (held_new == HELD_W'(BYTE_BITS))
                        begin
                            // Literal complete: emit only when the buffer has room.
                            if (buf_status.res_ready)
                            begin
                                emit       = 1'b1;
                                emit_data  = acc_new[BYTE_BITS-1:0];
                                phase_next = PH_FLAG;
                                acc_next   = '0;
                                held_next  = '0;
                                adv        = 1'b1;
                            end
                        end
                        else
                        begin
                            acc_next  = acc_new;
                            held_next = held_new;
                            adv       = 1'b1;
                        end
                    end

                    PH_MATCH:
                    begin
                        adv       = 1'b1;
                        acc_next  = acc_new;
                        held_next = held_new;
                        if (held_new == HELD_W'(MATCH_BITS))
                        begin
                            rd_ptr_next = acc_new[MATCH_BITS-1:LENGTH_BITS];
                            len_next    = LEN_W'(acc_new[LENGTH_BITS-1:0]) + LEN_W'(2);
                            phase_next  = PH_FLAG;
                            acc_next    = '0;
                            held_next   = '0;
                            go_copy     = 1'b1;
                        end
                    end

                    default:
                    begin
                        phase_next = PH_FLAG;
                    end
                endcase

                if (adv)
                begin
                    byte_next      = byte_reg << 1;
                    bits_left_next = bits_left_reg - 1'b1;
                    if (go_copy)
                    begin
                        state_next = ST_CP_ISSUE;
                    end
                    else if (bits_left_reg == BL_W'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_CP_ISSUE:
            begin
                // First window read of the match; nothing is written this cycle.
                ram_re      = 1'b1;
                rd_ptr_next = rd_ptr_reg + 1'b1;
                fwd_next    = 1'b0;
                state_next  = ST_CP_DATA;
            end

            ST_CP_DATA:
            begin
                if (buf_status.res_ready)
                begin
                    emit     = 1'b1;
                    len_next = len_reg - 1'b1;
                    if (len_reg == LEN_W'(1))
                    begin
                        fwd_next   = 1'b0;
                        state_next = (bits_left_reg == '0) ? ST_FLUSH : ST_BITS;
                    end
                    else
                    begin
                        // Next read; forward when it hits the byte written now.
                        ram_re        = 1'b1;
                        rd_ptr_next   = rd_ptr_reg + 1'b1;
                        fwd_next      = (rd_ptr_reg == wp_reg);
                        fwd_data_next = cp_data;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (buf_status.flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Every emitted byte goes into the window and advances the count.
        if (emit)
        begin
            ram_we     = 1'b1;
            wp_next    = wp_reg + 1'b1;
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_FLAG;
            clr_idx_reg   <= '0;
            byte_reg      <= '0;
            bits_left_reg <= '0;
            acc_reg       <= '0;
            held_reg      <= '0;
            wp_reg        <= PTR_START;
            rd_ptr_reg    <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            fwd_reg       <= 1'b0;
            fwd_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_idx_reg   <= clr_idx_next;
            byte_reg      <= byte_next;
            bits_left_reg <= bits_left_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            wp_reg        <= wp_next;
            rd_ptr_reg    <= rd_ptr_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            fwd_reg       <= fwd_next;
            fwd_data_reg  <= fwd_data_next;
        end
    end

    // Each emitted byte advances the write pointer by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && buf_status.res_ready) |=> wp_reg == win_addr_t'($past(wp_reg) + 1'b1))
        else $error("write pointer did not advance after an emitted byte");

    // Forwarded data is only meaningful while a copy is waiting on read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> (state_reg == ST_CP_DATA))
        else $error("forwarding flag set outside a match copy");

    // A copy in progress always has bytes left to move.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CP_DATA) |-> (len_reg != '0))
        else $error("match copy running with no bytes left");

    // A result and an end-of-byte flush never coincide.
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_ctrl.res_valid |-> !buf_ctrl.flush)
        else $error("result issued during flush");

endmodule

// ===== rtl/lzss_window_decompressor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor core
// Expands a flag/literal/match bit stream through a 256-byte ring window.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready carry total_length, the number of bytes to produce.
//   cfg_ready is always high; write it only while the core is idle.
//   in_valid/in_ready carry one compressed byte per transaction, read MSB
//   first. out_valid/out_ready carry one decompressed byte per transaction,
//   with last_of_run on the final byte caused by that input byte and
//   finished once the output count has reached total_length.
//   Sequence: each input byte is taken in its transaction, walked bit by
//   bit and then closes its run; a match of n bytes first issues a window
//   read, then moves its bytes through the window RAM read-modify-write
//   loop, 17 bytes for a full match. The next input byte is taken after
//   the previous one's results are all in the output stage; a result may
//   still wait in the output register.
//   Reset: the window RAM is cleared one entry per cycle, over every entry,
//   while in_ready stays low. A stalled receiver halts decoding in place.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_core
    import lzsswd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] total_length,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        finished
);

    lzsswd_buf_ctrl_t   buf_ctrl;
    lzsswd_buf_status_t buf_status;

    // The length register takes every configuration transaction at once.
    assign cfg_ready = 1'b1;

    // Bit parser, match copier and window RAM.
    lzsswd_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .total_length (total_length),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .buf_ctrl     (buf_ctrl),
        .buf_status   (buf_status)
    );

    // Pending result and output register.
    lzsswd_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .buf_ctrl    (buf_ctrl),
        .buf_status  (buf_status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .finished    (finished)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS window decompressor core testbench
// Drives compressed bytes and total_length writes into the core, predicts
// every decompressed byte with a behavioral copy of the bit stream decoder
// and its ring window, and checks each output transaction in order. A short
// directed table covers literals, overlapping and wrapping matches, the end
// of the stream and a token cut across a length change. Random phases follow
// with different sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
    import lzsswd_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 40;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    // Token decoding phase of the predictor.
    typedef enum logic [1:0] {AWAIT_FLAG, IN_LITERAL, IN_MATCH} token_phase_t;

    // Kind of one row of the directed table.
    typedef enum logic {ROW_LENGTH, ROW_BYTE} row_kind_t;

    // One decompressed byte as seen on the output channel.
    typedef struct packed {
        byte_t data;
        logic  last;
        logic  fin;
    } out_beat_t;

    // One directed row: a length write or a compressed byte. Rows marked
    // typed carry their expectation: no result, or a single result.
    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic        typed;
        logic        one_result;
        byte_t       exp_byte;
        logic        exp_fin;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 19;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Length is zero after reset: all bits are dropped.
        '{ROW_BYTE,   32'h0000_00FF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_0000, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_LENGTH, 32'd1000,      1'b0, 1'b0, 8'h00, 1'b0},
        // Literal 0xFF, then literal 0x00.
        '{ROW_BYTE,   32'h0000_00FF, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_00C0, 1'b1, 1'b1, 8'hFF, 1'b0},
        '{ROW_BYTE,   32'h0000_001D, 1'b1, 1'b1, 8'h00, 1'b0},
        // Longest match from the start pointer, overlapping its own output.
        '{ROW_BYTE,   32'h0000_00FE, 1'b0, 1'b0, 8'h00, 1'b0},
        // Shortest match from position zero, then literal 0xA5.
        '{ROW_BYTE,   32'h0000_0000, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_000D, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_002B, 1'b1, 1'b1, 8'hA5, 1'b0},
        // Match from the top position, wrapping around the window.
        '{ROW_BYTE,   32'h0000_00FC, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_00E7, 1'b0, 1'b0, 8'h00, 1'b0},
        // Literal 0x3C, then half a match held across a length change.
        '{ROW_BYTE,   32'h0000_008F, 1'b1, 1'b1, 8'h3C, 1'b0},
        '{ROW_LENGTH, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_0001, 1'b0, 1'b0, 8'h00, 1'b0},
        // Stream is finished: the byte is dropped.
        '{ROW_BYTE,   32'h0000_00FF, 1'b1, 1'b0, 8'h00, 1'b0},
        // Largest length resumes decoding with a literal 0x00.
        '{ROW_LENGTH, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_0080, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_BYTE,   32'h0000_007F, 1'b1, 1'b1, 8'h00, 1'b0}
    };

    // Block ports.
    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [31:0] total_length = '0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte      = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        finished;

    // Idling controls, in percent of cycles.
    int gap_pct   = 0;
    int stall_pct = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    // Decoder state of the predictor.
    byte_t        win_mem [WIN_SIZE];
    win_addr_t    wr_ptr       = PTR_START;
    logic [15:0]  bit_acc      = '0;
    int           bits_in      = 0;
    token_phase_t token_phase  = AWAIT_FLAG;
    count_t       emitted      = '0;
    count_t       length_limit = '0;

    // Decompressed bytes still awaited, and those of the current byte.
    out_beat_t expected_bytes [$];
    out_beat_t step_bytes [$];

    lzss_window_decompressor_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .total_length (total_length),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .finished     (finished)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The window starts cleared.
    initial
    begin
        foreach (win_mem[i])
            win_mem[i] = '0;
    end

    // Write one byte into the window and queue it as a result.
    function automatic void emit_window_byte(input byte_t c);
        win_mem[wr_ptr] = c;
        wr_ptr = wr_ptr + 1'b1;
        if (emitted != CNT_MAX)
            emitted = emitted + 1'b1;
        step_bytes.push_back('{c, 1'b0, (emitted >= length_limit)});
    endfunction

    // Run the bit stream decoder over one compressed byte, MSB first.
    function automatic void decode_byte(input byte_t b);
        int        i;
        int        k;
        int        copy_len;
        logic      bit_v;
        win_addr_t pos;
        step_bytes.delete();
        for (i = BYTE_BITS - 1; i >= 0; i--)
        begin
            bit_v = b[i];
            if (token_phase == AWAIT_FLAG)
            begin
                // A new token starts only while output is still owed.
                if (emitted < length_limit)
                begin
                    token_phase = bit_v ? IN_LITERAL : IN_MATCH;
                    bit_acc     = '0;
                    bits_in     = 0;
                end
            end
            else
            begin
                bit_acc = {bit_acc[14:0], bit_v};
                bits_in++;
                if (token_phase == IN_LITERAL && bits_in == BYTE_BITS)
                begin
                    emit_window_byte(bit_acc[7:0]);
                    token_phase = AWAIT_FLAG;
                end
                else if (token_phase == IN_MATCH && bits_in == MATCH_BITS)
                begin
                    // Copy byte by byte so that overlapping matches see
                    // the bytes they have just written.
                    pos      = bit_acc[MATCH_BITS-1:LENGTH_BITS];
                    copy_len = int'(bit_acc[LENGTH_BITS-1:0]) + 2;
                    for (k = 0; k < copy_len; k++)
                        emit_window_byte(win_mem[win_addr_t'(int'(pos) + k)]);
                    token_phase = AWAIT_FLAG;
                end
            end
        end
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].last = 1'b1;
    endfunction

    // Count a mismatch and report the first few.
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Send one compressed byte and queue what it should produce. Called
    // at a rising edge; returns at the edge that accepts the transaction,
    // with valid still high so that the next byte can follow at once.
    task automatic send_byte(input byte_t b, input logic typed,
                             input logic one_result, input byte_t exp_byte,
                             input logic exp_fin);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(negedge clk);
        while (!in_ready);
        decode_byte(b);
        if (typed)
        begin
            if (one_result)
                expected_bytes.push_back('{exp_byte, 1'b1, exp_fin});
        end
        else
        begin
            foreach (step_bytes[i])
                expected_bytes.push_back(step_bytes[i]);
        end
        @(posedge clk);
    endtask

    // Hold the sender off until every expected byte has come out. At least
    // one edge passes, so the sender never drives twice in one time step.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    // Write total_length once the core has gone idle.
    task automatic write_length(input count_t value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid    <= 1'b1;
        total_length <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        length_limit = value;
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver side: random back-pressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Output checker: sampled mid-cycle, away from the driving edge.
    always @(negedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result: byte %02h last %0b fin %0b",
                                        out_byte, last_of_run, finished));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data || last_of_run !== want.last ||
                    finished !== want.fin)
                begin
                    note_mismatch($sformatf(
                        "result mismatch: expected byte %02h last %0b fin %0b, got %02h %0b %0b",
                        want.data, want.last, want.fin, out_byte, last_of_run, finished));
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Stimulus: directed table, then random phases.
    initial
    begin
        int    ph;
        int    productive;
        byte_t b;
        count_t start_len;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, with light idling on both sides.
        gap_pct   = 7;
        stall_pct = 7;
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_LENGTH)
                write_length(DIRECTED[r].value);
            else
                send_byte(DIRECTED[r].value[7:0], DIRECTED[r].typed,
                          DIRECTED[r].one_result, DIRECTED[r].exp_byte,
                          DIRECTED[r].exp_fin);
        end

        // Random phases: no idling, idle sender, stalling receiver, both light.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 79; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 79; end
                default: begin gap_pct = 7; stall_pct = 7; end
            endcase
            case (ph)
                0: start_len = emitted + $urandom_range(60, 250);
                1: start_len = CNT_MAX;
                2: start_len = emitted + $urandom_range(30, 120);
                default: start_len = $urandom() | 32'h8000_0000;
            endcase
            write_length(start_len);

            productive = 0;
            while (productive < ITEMS_PER_PHASE)
            begin
                if (token_phase == AWAIT_FLAG && emitted >= length_limit)
                begin
                    // Stream finished: a few bytes are dropped, then the
                    // length is raised and decoding resumes.
                    repeat (2)
                    begin
                        b = byte_t'($urandom_range(0, 255));
                        send_byte(b, 1'b0, 1'b0, 8'h00, 1'b0);
                    end
                    write_length(emitted + $urandom_range(30, 200));
                end
                else
                begin
                    if (productive == ITEMS_PER_PHASE / 2)
                        wait_drained();
                    b = byte_t'($urandom_range(0, 255));
                    send_byte(b, 1'b0, 1'b0, 8'h00, 1'b0);
                    productive++;
                end
            end
        end

        // Drain, then give the core time to show any stray output.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lzsswd_pkg.sv
rtl/lzsswd_ram.sv
rtl/lzsswd_out_buf.sv
rtl/lzsswd_decoder.sv
rtl/lzss_window_decompressor_core.sv
tb/tb_top.sv
